### sv/kstod_pkg.sv
// Package with key codes, field widths and codes shared by the time-of-day clock.
`timescale 1ns / 1ps
`default_nettype none

package kstod_pkg;

    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int MODE_W  = 2;
    localparam int PHASE_W = 3;
    localparam int KEY_W   = 8;
    localparam int OUT_W   = 24;

    localparam logic [KEY_W-1:0] KEY_STORE   = 8'h31;
    localparam logic [KEY_W-1:0] KEY_RESTORE = 8'h32;
    localparam logic [KEY_W-1:0] KEY_START   = 8'h33;
    localparam logic [KEY_W-1:0] KEY_UP      = 8'h34;
    localparam logic [KEY_W-1:0] KEY_DOWN    = 8'h35;
    localparam logic [KEY_W-1:0] KEY_STOP    = 8'h36;
    localparam logic [KEY_W-1:0] KEY_NEXT    = 8'h37;
    localparam logic [KEY_W-1:0] KEY_SET     = 8'h38;

    localparam logic [MODE_W-1:0] MODE_UNSET = 2'd0;
    localparam logic [MODE_W-1:0] MODE_AM    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PM    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_24H   = 2'd3;

    localparam logic [PHASE_W-1:0] PHASE_NORMAL = 3'd0;
    localparam logic [PHASE_W-1:0] PHASE_MODE   = 3'd1;
    localparam logic [PHASE_W-1:0] PHASE_SEC    = 3'd2;
    localparam logic [PHASE_W-1:0] PHASE_MIN    = 3'd3;
    localparam logic [PHASE_W-1:0] PHASE_HOUR   = 3'd4;

    localparam logic [SEC_W-1:0]  SIXTY      = 6'd60;
    localparam logic [SEC_W-1:0]  SIX_MAX    = 6'd63;
    localparam logic [SEC_W-1:0]  SIX_TOP    = 6'd59;
    localparam logic [HOUR_W-1:0] HOUR_24    = 5'd24;
    localparam logic [HOUR_W-1:0] HOUR_12    = 5'd12;
    localparam logic [HOUR_W-1:0] HOUR_MAX   = 5'd31;
    localparam logic [HOUR_W-1:0] HOUR_TOP24 = 5'd23;
    localparam logic [HOUR_W-1:0] HOUR_TOP12 = 5'd11;

    // Up/down step on a seconds or minutes count with its wrap rules.
    function automatic logic [SEC_W-1:0] step_sixty(input logic [SEC_W-1:0] v,
                                                     input logic [KEY_W-1:0] key);
        logic [SEC_W-1:0] r;
        r = v;
        if (key == KEY_UP)
            r = r + 6'd1;
        if (key == KEY_DOWN)
            r = r - 6'd1;
        if (r == SIXTY)
            r = '0;
        if (r == SIX_MAX)
            r = SIX_TOP;
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/keypad_set_time_of_day_clock_unit.sv
// Top level of the keypad-set time-of-day clock with 12/24 hour modes.
// A request is held in the input register, then its result is registered in the result register.
// Throughput: one request per cycle while the output does not stall; the clock state updates in a single pass.
// The input register and the result register each hold while the output stalls.
// Reset (rst_n low, asynchronous) clears time, mode, saved copy and LED,
// stops the clock and leaves it in the mode-setting step.
`timescale 1ns / 1ps
`default_nettype none

module keypad_set_time_of_day_clock_unit
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [kstod_pkg::KEY_W-1:0]     s_tdata,   // key_code[7:0]
    input  wire logic                            s_tuser,   // func[0]
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // hours[4:0], minutes[10:5], seconds[16:11], clock_mode[18:17],
    // running[19], set_phase[22:20], led[23]
    output logic [kstod_pkg::OUT_W-1:0]          m_tdata
);

    // Input stage
    logic                        in_valid_reg;
    logic                        in_func_reg;
    logic [kstod_pkg::KEY_W-1:0] in_key_reg;

    // Clock state
    logic [kstod_pkg::SEC_W-1:0]   sec_reg, sec_next;
    logic [kstod_pkg::MIN_W-1:0]   min_reg, min_next;
    logic [kstod_pkg::HOUR_W-1:0]  hour_reg, hour_next;
    logic [kstod_pkg::MODE_W-1:0]  mode_reg, mode_next;
    logic                          run_reg, run_next;
    logic [kstod_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic                          led_reg, led_next;
    logic [kstod_pkg::SEC_W-1:0]   saved_sec_reg, saved_sec_next;
    logic [kstod_pkg::MIN_W-1:0]   saved_min_reg, saved_min_next;
    logic [kstod_pkg::HOUR_W-1:0]  saved_hour_reg, saved_hour_next;

    // Result stage
    logic                        out_valid_reg;
    logic [kstod_pkg::OUT_W-1:0] out_data_reg;

    logic advance;
    logic fire;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = advance && in_valid_reg;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        logic [kstod_pkg::SEC_W-1:0]  sec_inc;
        logic [kstod_pkg::MIN_W-1:0]  min_inc;
        logic [kstod_pkg::HOUR_W-1:0] hour_tmp;

        sec_next        = sec_reg;
        min_next        = min_reg;
        hour_next       = hour_reg;
        mode_next       = mode_reg;
        run_next        = run_reg;
        phase_next      = phase_reg;
        led_next        = led_reg;
        saved_sec_next  = saved_sec_reg;
        saved_min_next  = saved_min_reg;
        saved_hour_next = saved_hour_reg;
        sec_inc         = sec_reg + 6'd1;
        min_inc         = min_reg + 6'd1;
        hour_tmp        = hour_reg;

        if (!in_func_reg) begin
            if (run_reg) begin
                led_next = !led_reg;
                sec_next = sec_inc;
                // Only the step from 59 to 60 carries into the next field.
                if (sec_inc == kstod_pkg::SIXTY) begin
                    sec_next = '0;
                    min_next = min_inc;
                    if (min_inc == kstod_pkg::SIXTY) begin
                        min_next = '0;
                        hour_tmp = hour_reg + 5'd1;
                        if (hour_tmp == kstod_pkg::HOUR_12 &&
                            (mode_reg == kstod_pkg::MODE_AM ||
                             mode_reg == kstod_pkg::MODE_PM)) begin
                            mode_next = (mode_reg == kstod_pkg::MODE_AM) ?
                                        kstod_pkg::MODE_PM : kstod_pkg::MODE_AM;
                            hour_tmp  = '0;
                        end
                        if (hour_tmp == kstod_pkg::HOUR_24)
                            hour_tmp = '0;
                        hour_next = hour_tmp;
                    end
                end
            end
        end else if (phase_reg != kstod_pkg::PHASE_NORMAL) begin
            case (phase_reg)
                kstod_pkg::PHASE_MODE:
                begin
                    if (in_key_reg == kstod_pkg::KEY_UP)
                        mode_next = mode_reg + 2'd1;
                    if (mode_next == kstod_pkg::MODE_UNSET)
                        mode_next = kstod_pkg::MODE_AM;
                end
                kstod_pkg::PHASE_SEC:
                    sec_next = kstod_pkg::step_sixty(sec_reg, in_key_reg);
                kstod_pkg::PHASE_MIN:
                    min_next = kstod_pkg::step_sixty(min_reg, in_key_reg);
                default:
                begin
                    if (in_key_reg == kstod_pkg::KEY_UP)
                        hour_tmp = hour_reg + 5'd1;
                    if (in_key_reg == kstod_pkg::KEY_DOWN)
                        hour_tmp = hour_reg - 5'd1;
                    if (mode_reg == kstod_pkg::MODE_24H) begin
                        if (hour_tmp == kstod_pkg::HOUR_24)
                            hour_tmp = '0;
                        if (hour_tmp == kstod_pkg::HOUR_MAX)
                            hour_tmp = kstod_pkg::HOUR_TOP24;
                    end
                    if (mode_reg == kstod_pkg::MODE_AM || mode_reg == kstod_pkg::MODE_PM) begin
                        if (hour_tmp == kstod_pkg::HOUR_12)
                            hour_tmp = '0;
                        if (hour_tmp == kstod_pkg::HOUR_MAX)
                            hour_tmp = kstod_pkg::HOUR_TOP12;
                    end
                    hour_next = hour_tmp;
                end
            endcase
            if (in_key_reg == kstod_pkg::KEY_NEXT) begin
                if (phase_reg >= kstod_pkg::PHASE_HOUR) begin
                    phase_next = kstod_pkg::PHASE_NORMAL;
                    run_next   = 1'b1;
                end else begin
                    phase_next = phase_reg + 3'd1;
                end
            end
        end else begin
            case (in_key_reg)
                kstod_pkg::KEY_STOP:
                    run_next = 1'b0;
                kstod_pkg::KEY_START:
                    run_next = 1'b1;
                kstod_pkg::KEY_NEXT:
                begin
                    sec_next  = '0;
                    min_next  = '0;
                    hour_next = '0;
                end
                kstod_pkg::KEY_SET:
                begin
                    run_next   = 1'b0;
                    phase_next = kstod_pkg::PHASE_MODE;
                end
                kstod_pkg::KEY_RESTORE:
                begin
                    sec_next  = saved_sec_reg;
                    min_next  = saved_min_reg;
                    hour_next = saved_hour_reg;
                end
                kstod_pkg::KEY_STORE:
                begin
                    saved_sec_next  = sec_reg;
                    saved_min_next  = min_reg;
                    saved_hour_next = hour_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            sec_reg        <= '0;
            min_reg        <= '0;
            hour_reg       <= '0;
            mode_reg       <= kstod_pkg::MODE_UNSET;
            run_reg        <= 1'b0;
            phase_reg      <= kstod_pkg::PHASE_MODE;
            led_reg        <= 1'b0;
            saved_sec_reg  <= '0;
            saved_min_reg  <= '0;
            saved_hour_reg <= '0;
        end else begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (fire) begin
                sec_reg        <= sec_next;
                min_reg        <= min_next;
                hour_reg       <= hour_next;
                mode_reg       <= mode_next;
                run_reg        <= run_next;
                phase_reg      <= phase_next;
                led_reg        <= led_next;
                saved_sec_reg  <= saved_sec_next;
                saved_min_reg  <= saved_min_next;
                saved_hour_reg <= saved_hour_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid) begin
            in_func_reg <= s_tuser;
            in_key_reg  <= s_tdata;
        end
        if (fire)
            out_data_reg <= {led_next, phase_next, run_next, mode_next,
                             sec_next, min_next, hour_next};
    end

    // The clock only runs outside of setting.
    assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> (phase_reg == kstod_pkg::PHASE_NORMAL))
    else $error("clock running while a setting step is active");

    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= kstod_pkg::PHASE_HOUR)
    else $error("setting step out of range");

    // Once chosen, the mode never returns to unset.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != kstod_pkg::MODE_UNSET) |=> (mode_reg != kstod_pkg::MODE_UNSET))
    else $error("clock mode fell back to unset");

    // The LED moves only on a counted tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        !fire || in_func_reg || !run_reg |=> $stable(led_reg))
    else $error("LED toggled without a counted tick");

endmodule

`default_nettype wire

### tb/keypad_set_time_of_day_clock_unit_tb.sv
// Self-checking stream testbench for the keypad-set time-of-day clock unit.
`timescale 1ns / 1ps

module keypad_set_time_of_day_clock_unit_tb;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_KEY  = 1'b1;

    localparam int RANDOM_ITEMS = 1100;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic                          led;
        logic [kstod_pkg::PHASE_W-1:0] set_phase;
        logic                          running;
        logic [kstod_pkg::MODE_W-1:0]  clock_mode;
        logic [kstod_pkg::SEC_W-1:0]   seconds;
        logic [kstod_pkg::MIN_W-1:0]   minutes;
        logic [kstod_pkg::HOUR_W-1:0]  hours;
    } clock_face_t;

    typedef struct {
        logic                        func;
        logic [kstod_pkg::KEY_W-1:0] key;
        bit                          known;
        clock_face_t                 face;
    } stim_row_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [kstod_pkg::KEY_W-1:0] s_tdata;   // key_code[7:0]
    logic                        s_tuser;   // func[0]
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    // hours[4:0], minutes[10:5], seconds[16:11], clock_mode[18:17],
    // running[19], set_phase[22:20], led[23]
    logic [kstod_pkg::OUT_W-1:0] m_tdata;

    keypad_set_time_of_day_clock_unit u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predicted clock state, kept in step with every accepted request.
    logic [kstod_pkg::SEC_W-1:0]   t_sec     = '0;
    logic [kstod_pkg::MIN_W-1:0]   t_min     = '0;
    logic [kstod_pkg::HOUR_W-1:0]  t_hour    = '0;
    logic [kstod_pkg::MODE_W-1:0]  t_mode    = kstod_pkg::MODE_UNSET;
    logic                          t_run     = 1'b0;
    logic [kstod_pkg::PHASE_W-1:0] t_phase   = kstod_pkg::PHASE_MODE;
    logic                          t_led     = 1'b0;
    logic [kstod_pkg::SEC_W-1:0]   keep_sec  = '0;
    logic [kstod_pkg::MIN_W-1:0]   keep_min  = '0;
    logic [kstod_pkg::HOUR_W-1:0]  keep_hour = '0;

    clock_face_t faces_due[$];
    stim_row_t   directed_rows[$];

    int src_idle_pct  = 34;
    int sink_idle_pct = 73;
    int hold_asked    = 0;
    int hold_taken    = 0;
    int hold_left     = 0;

    int cycle_count     = 0;
    int mismatches      = 0;
    int req_sent        = 0;
    int ticks_sent      = 0;
    int keys_sent       = 0;
    int results_checked = 0;
    int hour_rollovers  = 0;
    int ampm_flips      = 0;

    function automatic logic [kstod_pkg::KEY_W-1:0] rand_key();
        logic [31:0] v;
        v = $urandom_range(255);
        return v[kstod_pkg::KEY_W-1:0];
    endfunction

    function automatic logic rand_func();
        logic [31:0] v;
        v = $urandom_range(1);
        return v[0];
    endfunction

    function automatic logic [kstod_pkg::SEC_W-1:0] nudge_sixty(
        input logic [kstod_pkg::SEC_W-1:0] v,
        input logic [kstod_pkg::KEY_W-1:0] k);
        logic [kstod_pkg::SEC_W-1:0] r;
        r = v;
        if (k == kstod_pkg::KEY_UP)
            r = r + 1'b1;
        if (k == kstod_pkg::KEY_DOWN)
            r = r - 1'b1;
        if (r == kstod_pkg::SIXTY)
            r = '0;
        if (r == kstod_pkg::SIX_MAX)
            r = kstod_pkg::SIX_TOP;
        return r;
    endfunction

    function automatic clock_face_t apply_request(input logic f,
                                                  input logic [kstod_pkg::KEY_W-1:0] k);
        clock_face_t r;
        if (f == FUNC_TICK) begin
            if (t_run) begin
                t_sec = t_sec + 1'b1;
                if (t_sec == kstod_pkg::SIXTY) begin
                    t_sec = '0;
                    t_min = t_min + 1'b1;
                    if (t_min == kstod_pkg::SIXTY) begin
                        t_min  = '0;
                        t_hour = t_hour + 1'b1;
                        hour_rollovers++;
                        if ((t_mode == kstod_pkg::MODE_AM || t_mode == kstod_pkg::MODE_PM) &&
                            t_hour == kstod_pkg::HOUR_12) begin
                            t_mode = (t_mode == kstod_pkg::MODE_AM) ?
                                     kstod_pkg::MODE_PM : kstod_pkg::MODE_AM;
                            t_hour = '0;
                            ampm_flips++;
                        end
                        if (t_hour == kstod_pkg::HOUR_24)
                            t_hour = '0;
                    end
                end
                t_led = ~t_led;
            end
        end
        else if (t_phase != kstod_pkg::PHASE_NORMAL) begin
            case (t_phase)
                kstod_pkg::PHASE_MODE:
                begin
                    if (k == kstod_pkg::KEY_UP)
                        t_mode = t_mode + 1'b1;
                    if (t_mode == kstod_pkg::MODE_UNSET)
                        t_mode = kstod_pkg::MODE_AM;
                end
                kstod_pkg::PHASE_SEC: t_sec = nudge_sixty(t_sec, k);
                kstod_pkg::PHASE_MIN: t_min = nudge_sixty(t_min, k);
                default:
                begin
                    if (k == kstod_pkg::KEY_UP)
                        t_hour = t_hour + 1'b1;
                    if (k == kstod_pkg::KEY_DOWN)
                        t_hour = t_hour - 1'b1;
                    if (t_mode == kstod_pkg::MODE_24H) begin
                        if (t_hour == kstod_pkg::HOUR_24)
                            t_hour = '0;
                        if (t_hour == kstod_pkg::HOUR_MAX)
                            t_hour = kstod_pkg::HOUR_TOP24;
                    end
                    if (t_mode == kstod_pkg::MODE_AM || t_mode == kstod_pkg::MODE_PM) begin
                        if (t_hour == kstod_pkg::HOUR_12)
                            t_hour = '0;
                        if (t_hour == kstod_pkg::HOUR_MAX)
                            t_hour = kstod_pkg::HOUR_TOP12;
                    end
                end
            endcase
            if (k == kstod_pkg::KEY_NEXT) begin
                if (t_phase >= kstod_pkg::PHASE_HOUR) begin
                    t_phase = kstod_pkg::PHASE_NORMAL;
                    t_run   = 1'b1;
                end
                else begin
                    t_phase = t_phase + 1'b1;
                end
            end
        end
        else begin
            case (k)
                kstod_pkg::KEY_STOP:  t_run = 1'b0;
                kstod_pkg::KEY_START: t_run = 1'b1;
                kstod_pkg::KEY_NEXT:
                begin
                    t_sec  = '0;
                    t_min  = '0;
                    t_hour = '0;
                end
                kstod_pkg::KEY_SET:
                begin
                    t_run   = 1'b0;
                    t_phase = kstod_pkg::PHASE_MODE;
                end
                kstod_pkg::KEY_RESTORE:
                begin
                    t_sec  = keep_sec;
                    t_min  = keep_min;
                    t_hour = keep_hour;
                end
                kstod_pkg::KEY_STORE:
                begin
                    keep_sec  = t_sec;
                    keep_min  = t_min;
                    keep_hour = t_hour;
                end
                default: ;
            endcase
        end
        r.hours      = t_hour;
        r.minutes    = t_min;
        r.seconds    = t_sec;
        r.clock_mode = t_mode;
        r.running    = t_run;
        r.set_phase  = t_phase;
        r.led        = t_led;
        return r;
    endfunction

    function automatic clock_face_t face_of(input int h, input int m, input int s,
                                            input logic [kstod_pkg::MODE_W-1:0] mode,
                                            input logic run,
                                            input logic [kstod_pkg::PHASE_W-1:0] phase,
                                            input logic led);
        clock_face_t r;
        r.hours      = h[kstod_pkg::HOUR_W-1:0];
        r.minutes    = m[kstod_pkg::MIN_W-1:0];
        r.seconds    = s[kstod_pkg::SEC_W-1:0];
        r.clock_mode = mode;
        r.running    = run;
        r.set_phase  = phase;
        r.led        = led;
        return r;
    endfunction

    function automatic void add_row(input logic f, input logic [kstod_pkg::KEY_W-1:0] k,
                                    input bit known, input clock_face_t face);
        stim_row_t row;
        row.func  = f;
        row.key   = k;
        row.known = known;
        row.face  = face;
        directed_rows.push_back(row);
    endfunction

    // Offers one request, with a random gap before it, and records its expected result.
    task automatic send_item(input logic f, input logic [kstod_pkg::KEY_W-1:0] k,
                             input bit known, input clock_face_t typed);
        clock_face_t face;
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= k;
        do
            @(posedge clk);
        while (!s_tready);
        face = apply_request(f, k);
        faces_due.push_back(known ? typed : face);
        req_sent++;
        if (f == FUNC_TICK)
            ticks_sent++;
        else
            keys_sent++;
    endtask

    task automatic send_key(input logic [kstod_pkg::KEY_W-1:0] k);
        send_item(FUNC_KEY, k, 1'b0, '0);
    endtask

    task automatic send_tick();
        send_item(FUNC_TICK, 8'h00, 1'b0, '0);
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (faces_due.size() != 0)
            @(posedge clk);
    endtask

    // One setting step. When aiming, the field is walked to its top value so that
    // the ticks after the session carry into the next field.
    task automatic set_field(input bit aim, input int cur, input int top);
        int n;
        logic [kstod_pkg::KEY_W-1:0] dir;
        if (aim && cur <= top) begin
            if (top - cur <= cur + 1)
                repeat (top - cur) send_key(kstod_pkg::KEY_UP);
            else
                repeat (cur + 1) send_key(kstod_pkg::KEY_DOWN);
        end
        else begin
            n   = $urandom_range(3);
            dir = $urandom_range(1) ? kstod_pkg::KEY_UP : kstod_pkg::KEY_DOWN;
            repeat (n) send_key(dir);
            if ($urandom_range(3) == 0)
                send_key(rand_key());
        end
        send_key(kstod_pkg::KEY_NEXT);
    endtask

    task automatic run_session();
        bit aim;
        int n;
        logic [kstod_pkg::KEY_W-1:0] k;
        aim = ($urandom_range(99) < 45);
        send_key(kstod_pkg::KEY_SET);
        n = $urandom_range(3);
        repeat (n)
            send_key(($urandom_range(3) == 0) ? kstod_pkg::KEY_DOWN : kstod_pkg::KEY_UP);
        send_key(kstod_pkg::KEY_NEXT);
        set_field(aim, int'(t_sec), int'(kstod_pkg::SIX_TOP));
        set_field(aim, int'(t_min), int'(kstod_pkg::SIX_TOP));
        set_field(aim, int'(t_hour),
                  (t_mode == kstod_pkg::MODE_24H) ? int'(kstod_pkg::HOUR_TOP24)
                                                  : int'(kstod_pkg::HOUR_TOP12));
        n = $urandom_range(1, 12);
        repeat (n) begin
            if ($urandom_range(99) < 80) begin
                send_tick();
            end
            else begin
                case ($urandom_range(5))
                    0:       k = kstod_pkg::KEY_STORE;
                    1:       k = kstod_pkg::KEY_RESTORE;
                    2:       k = kstod_pkg::KEY_STOP;
                    3:       k = kstod_pkg::KEY_START;
                    4:       k = kstod_pkg::KEY_NEXT;
                    default: k = rand_key();
                endcase
                send_key(k);
            end
        end
    endtask

    task automatic check_face(input clock_face_t got);
        clock_face_t want;
        if (faces_due.size() == 0) begin
            $error("result with no request waiting: %h", got);
            mismatches++;
        end
        else begin
            want = faces_due.pop_front();
            results_checked++;
            if (got.hours !== want.hours) begin
                $error("hours: expected %0d, actual %0d", want.hours, got.hours);
                mismatches++;
            end
            if (got.minutes !== want.minutes) begin
                $error("minutes: expected %0d, actual %0d", want.minutes, got.minutes);
                mismatches++;
            end
            if (got.seconds !== want.seconds) begin
                $error("seconds: expected %0d, actual %0d", want.seconds, got.seconds);
                mismatches++;
            end
            if (got.clock_mode !== want.clock_mode) begin
                $error("clock_mode: expected %0d, actual %0d", want.clock_mode, got.clock_mode);
                mismatches++;
            end
            if (got.running !== want.running) begin
                $error("running: expected %0d, actual %0d", want.running, got.running);
                mismatches++;
            end
            if (got.set_phase !== want.set_phase) begin
                $error("set_phase: expected %0d, actual %0d", want.set_phase, got.set_phase);
                mismatches++;
            end
            if (got.led !== want.led) begin
                $error("led: expected %0d, actual %0d", want.led, got.led);
                mismatches++;
            end
        end
    endtask

    // Result side: checks each accepted result and drives tready, including the
    // long hold-off that backs the block up into its input.
    always @(posedge clk)
    begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end
        else begin
            if (m_tvalid && m_tready)
                check_face(m_tdata);
            if (hold_taken != hold_asked) begin
                hold_taken = hold_asked;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else begin
                m_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int stage;
        int dir_count;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = FUNC_TICK;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk through every mode and the setting wraps in 24-hour mode, then a full
        // day rollover, the saved copy, and a tick while stopped.
        add_row(FUNC_TICK, 8'h00, 1,
                face_of(0, 0, 0, kstod_pkg::MODE_UNSET, 0, kstod_pkg::PHASE_MODE, 0));
        add_row(FUNC_KEY, kstod_pkg::KEY_DOWN, 1,
                face_of(0, 0, 0, kstod_pkg::MODE_AM, 0, kstod_pkg::PHASE_MODE, 0));
        add_row(FUNC_KEY, kstod_pkg::KEY_UP, 1,
                face_of(0, 0, 0, kstod_pkg::MODE_PM, 0, kstod_pkg::PHASE_MODE, 0));
        add_row(FUNC_KEY, kstod_pkg::KEY_UP, 1,
                face_of(0, 0, 0, kstod_pkg::MODE_24H, 0, kstod_pkg::PHASE_MODE, 0));
        add_row(FUNC_KEY, kstod_pkg::KEY_UP, 1,
                face_of(0, 0, 0, kstod_pkg::MODE_AM, 0, kstod_pkg::PHASE_MODE, 0));
        add_row(FUNC_KEY, kstod_pkg::KEY_UP, 0, '0);
        add_row(FUNC_KEY, kstod_pkg::KEY_UP, 0, '0);
        add_row(FUNC_KEY, kstod_pkg::KEY_NEXT, 1,
                face_of(0, 0, 0, kstod_pkg::MODE_24H, 0, kstod_pkg::PHASE_SEC, 0));
        add_row(FUNC_KEY, kstod_pkg::KEY_DOWN, 1,
                face_of(0, 0, 59, kstod_pkg::MODE_24H, 0, kstod_pkg::PHASE_SEC, 0));
        add_row(FUNC_KEY, kstod_pkg::KEY_UP, 1,
                face_of(0, 0, 0, kstod_pkg::MODE_24H, 0, kstod_pkg::PHASE_SEC, 0));
        add_row(FUNC_KEY, kstod_pkg::KEY_DOWN, 0, '0);
        add_row(FUNC_KEY, kstod_pkg::KEY_NEXT, 0, '0);
        add_row(FUNC_KEY, kstod_pkg::KEY_DOWN, 0, '0);
        add_row(FUNC_KEY, kstod_pkg::KEY_NEXT, 0, '0);
        add_row(FUNC_KEY, kstod_pkg::KEY_DOWN, 1,
                face_of(23, 59, 59, kstod_pkg::MODE_24H, 0, kstod_pkg::PHASE_HOUR, 0));
        add_row(FUNC_KEY, kstod_pkg::KEY_UP, 1,
                face_of(0, 59, 59, kstod_pkg::MODE_24H, 0, kstod_pkg::PHASE_HOUR, 0));
        add_row(FUNC_KEY, kstod_pkg::KEY_DOWN, 0, '0);
        add_row(FUNC_KEY, kstod_pkg::KEY_NEXT, 1,
                face_of(23, 59, 59, kstod_pkg::MODE_24H, 1, kstod_pkg::PHASE_NORMAL, 0));
        add_row(FUNC_TICK, 8'h00, 1,
                face_of(0, 0, 0, kstod_pkg::MODE_24H, 1, kstod_pkg::PHASE_NORMAL, 1));
        add_row(FUNC_TICK, 8'hFF, 0, '0);
        add_row(FUNC_KEY, kstod_pkg::KEY_STORE, 0, '0);
        add_row(FUNC_KEY, kstod_pkg::KEY_NEXT, 0, '0);
        add_row(FUNC_KEY, kstod_pkg::KEY_RESTORE, 0, '0);
        add_row(FUNC_KEY, kstod_pkg::KEY_STOP, 0, '0);
        add_row(FUNC_TICK, 8'h00, 0, '0);
        add_row(FUNC_KEY, kstod_pkg::KEY_START, 0, '0);
        add_row(FUNC_KEY, kstod_pkg::KEY_SET, 0, '0);
        foreach (directed_rows[i])
            send_item(directed_rows[i].func, directed_rows[i].key,
                      directed_rows[i].known, directed_rows[i].face);
        dir_count = req_sent;

        stage = 0;
        while (req_sent < dir_count + RANDOM_ITEMS) begin
            if (stage == 0 && req_sent >= dir_count + RANDOM_ITEMS / 3) begin
                stage = 1;
                wait_all_results();
                src_idle_pct  = 73;
                sink_idle_pct = 34;
            end
            else if (stage == 1 && req_sent >= dir_count + 2 * RANDOM_ITEMS / 3) begin
                stage = 2;
                src_idle_pct  = 0;
                sink_idle_pct = 0;
                hold_asked++;
            end
            if ($urandom_range(99) < 75)
                run_session();
            else
                repeat ($urandom_range(1, 5))
                    send_item(rand_func(), rand_key(), 1'b0, '0);
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d requests (%0d ticks, %0d key presses), %0d results checked.",
                 req_sent, ticks_sent, keys_sent, results_checked);
        $display("Saw %0d hour carries and %0d AM/PM flips; %0d mismatches.",
                 hour_rollovers, ampm_flips, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
